@@ design/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Implication checked in the cycle after the condition.
`define CHK_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

@@ design/sacd_pkg.sv @@
// ----------------------------------------------------------------------------
// Package of the set-associative cache directory
// Shared widths, item kinds and hash constants.
// ----------------------------------------------------------------------------
package sacd_pkg;
  localparam int unsigned NumSetsDefault = 64;
  localparam int unsigned NumWaysDefault = 4;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [8:0]  CountMax = 9'd511;

  typedef enum logic [2:0] {
    KIND_LOOKUP   = 3'd0,
    KIND_FILL     = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_INV_BLK  = 3'd3,
    KIND_INV_DEV  = 3'd4,
    KIND_FLUSH    = 3'd5,
    KIND_COUNT    = 3'd6,
    KIND_NONE     = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  device_id;
    logic [47:0] block_address;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] set_index;
    logic [1:0] way;
    logic [8:0] line_count;
  } rsp_t;
endpackage

@@ design/sacd_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sacd_req_if;
  logic            valid;
  logic            ready;
  sacd_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/sacd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sacd_rsp_if;
  logic            valid;
  logic            ready;
  sacd_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/set_assoc_block_cache_directory_top.sv @@
// ----------------------------------------------------------------------------
// Set-associative block cache directory
// Block kinds: 16 hash steps on one shared multiplier, then the set reduction,
// a read and a compare for each way, then the write-back and the result.
// Device, flush and count kinds walk every line, reading and comparing each in turn.
// Reset: rst clears valid bits via a sweep over all NUM_SETS*NUM_WAYS lines.
// ----------------------------------------------------------------------------
module set_assoc_block_cache_directory_top #(
  parameter int unsigned NUM_SETS = sacd_pkg::NumSetsDefault,
  parameter int unsigned NUM_WAYS = sacd_pkg::NumWaysDefault
) (
  input logic     clk,
  input logic     rst,
  sacd_req_if.sink   req,
  sacd_rsp_if.source rsp
);
  // Sizes derived from the parameters.
  localparam int unsigned Lines = NUM_SETS * NUM_WAYS;
  localparam int unsigned LW = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned WCW = $clog2(NUM_WAYS + 1);
  localparam int unsigned LCW = $clog2(Lines + 1);
  // Reciprocal of the set count for the reduction; the estimated quotient is
  // at most one short, so a single compare and subtract finishes the job.
  localparam logic [31:0] RecipSets = 32'((64'd1 << 32) / 64'(NUM_SETS));

  // The line stores are memories with one read and one write port; valid
  // bits are a memory too and are cleared by a sweep after reset.
  logic        valid_mem [Lines];
  logic [7:0]  dev_mem   [Lines];
  logic [47:0] blk_mem   [Lines];
  logic [31:0] stamp_mem [Lines];

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH_X, ST_HASH_M, ST_MOD, ST_MOD_Q, ST_MOD_R,
    ST_MOD_FIX, ST_RD, ST_RD_WAIT, ST_CMP, ST_WRITE, ST_WALK_RD, ST_WALK_CMP,
    ST_RESP
  } state_t;

  state_t      state;
  sacd_pkg::req_t cur;
  logic [31:0] hash;
  logic [63:0] prod;
  logic [3:0]  step;
  logic [SW-1:0] set_sel;
  logic [LCW-1:0] idx;       // way counter in scans, line counter in the reset sweep
  logic [LW-1:0] line_addr;
  logic        rd_valid;
  logic [7:0]  rd_dev;
  logic [47:0] rd_blk;
  logic [31:0] rd_stamp;
  logic        found;
  logic [WW-1:0] found_way;
  logic        have_free;
  logic [WW-1:0] free_way;
  logic [WW-1:0] old_way;
  logic [31:0] old_stamp;
  logic        old_any;
  logic [8:0]  count;
  logic        wr_en;
  logic [LW-1:0] wr_addr;
  logic        wr_valid;
  logic        wr_full;
  logic        wr_stamp_only;
  sacd_pkg::rsp_t out;
  logic        out_valid;

  // Shared multiplier operand and hash byte selection.
  logic [7:0]  hash_byte;
  logic [63:0] hash_src;
  logic [LW-1:0] scan_addr;
  logic        match;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    hash_src  = (step < 4'd8) ? {56'd0, cur.device_id} : {16'd0, cur.block_address};
    hash_byte = hash_src[{step[2:0], 3'b000} +: 8];
    scan_addr = LW'(set_sel) * LW'(NUM_WAYS) + LW'(idx[WW-1:0]);
    match = rd_valid && (rd_dev == cur.device_id) && (rd_blk == cur.block_address);
    // The one multiplier serves the hash steps and both reduction products.
    case (state)
      ST_MOD: begin
        mul_a = hash;
        mul_b = RecipSets;
      end
      ST_MOD_Q: begin
        mul_a = prod[63:32];
        mul_b = 32'(NUM_SETS);
      end
      default: begin
        mul_a = hash ^ {24'd0, hash_byte};
        mul_b = sacd_pkg::FnvPrime;
      end
    endcase
  end

  // A new item may be taken while the previous result still waits in the
  // output register; the sequencer only stalls if it reaches ST_RESP first.
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
      if (wr_full) begin
        dev_mem[wr_addr] <= cur.device_id;
        blk_mem[wr_addr] <= cur.block_address;
      end
      if (wr_full || wr_stamp_only) begin
        stamp_mem[wr_addr] <= cur.now;
      end
    end
    rd_valid <= valid_mem[line_addr];
    rd_dev   <= dev_mem[line_addr];
    rd_blk   <= blk_mem[line_addr];
    rd_stamp <= stamp_mem[line_addr];
  end

  always_ff @(posedge clk) begin
    wr_en         <= 1'b0;
    wr_full       <= 1'b0;
    wr_stamp_only <= 1'b0;
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
      wr_en     <= 1'b1;
      wr_addr   <= '0;
      wr_valid  <= 1'b0;
      line_addr <= '0;
    end else begin
      if (out_valid && rsp.ready && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          // Only the valid bits need clearing; stamps are read for valid lines only.
          wr_en         <= 1'b1;
          wr_stamp_only <= 1'b0;
          wr_addr       <= idx[LW-1:0];
          wr_valid      <= 1'b0;
          if (idx == LCW'(Lines - 1)) begin
            state <= ST_IDLE;
          end
          idx <= idx + 1'b1;
        end
        ST_IDLE: begin
          if (req.valid) begin
            cur   <= req.data;
            hash  <= sacd_pkg::FnvBasis;
            step  <= '0;
            idx   <= '0;
            count <= '0;
            found <= 1'b0;
            found_way <= '0;
            have_free <= 1'b0;
            free_way  <= '0;
            old_way   <= '0;
            old_any   <= 1'b0;
            old_stamp <= '0;
            set_sel   <= '0;
            case (sacd_pkg::kind_t'(req.data.kind))
              sacd_pkg::KIND_LOOKUP, sacd_pkg::KIND_FILL,
              sacd_pkg::KIND_WRITE, sacd_pkg::KIND_INV_BLK: state <= ST_HASH_X;
              sacd_pkg::KIND_INV_DEV, sacd_pkg::KIND_FLUSH,
              sacd_pkg::KIND_COUNT: begin
                line_addr <= '0;
                state     <= ST_WALK_RD;
              end
              default: state <= ST_RESP;
            endcase
          end
        end
        ST_HASH_X: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_HASH_M;
        end
        ST_HASH_M: begin
          hash <= prod[31:0];
          step <= step + 1'b1;
          state <= (step == 4'd15) ? ST_MOD : ST_HASH_X;
        end
        ST_MOD: begin
          // Quotient estimate: hash times the reciprocal, upper half.
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_MOD_Q;
        end
        ST_MOD_Q: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          state <= ST_MOD_R;
        end
        ST_MOD_R: begin
          hash  <= hash - prod[31:0];
          state <= ST_MOD_FIX;
        end
        ST_MOD_FIX: begin
          if (hash >= 32'(NUM_SETS)) begin
            hash <= hash - 32'(NUM_SETS);
          end else begin
            set_sel <= SW'(hash);
            state   <= ST_RD;
          end
        end
        ST_RD: begin
          line_addr <= scan_addr;
          state     <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          // The memory samples the new address at this edge.
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (ST_CMP == state) begin
            if (match) begin
              if (!found) begin
                found_way <= idx[WW-1:0];
              end
              found <= 1'b1;
              if (sacd_pkg::kind_t'(cur.kind) == sacd_pkg::KIND_INV_BLK) begin
                wr_en    <= 1'b1;
                wr_addr  <= line_addr;
                wr_valid <= 1'b0;
              end
            end
            if (!rd_valid && !have_free) begin
              have_free <= 1'b1;
              free_way  <= idx[WW-1:0];
            end
            if (rd_valid && (!old_any || rd_stamp < old_stamp)) begin
              old_any   <= 1'b1;
              old_stamp <= rd_stamp;
              old_way   <= idx[WW-1:0];
            end
            if (idx == LCW'(NUM_WAYS - 1)) begin
              state <= ST_WRITE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_RD;
            end
          end
        end
        ST_WRITE: begin
          state <= ST_RESP;
          case (sacd_pkg::kind_t'(cur.kind))
            sacd_pkg::KIND_LOOKUP, sacd_pkg::KIND_WRITE: begin
              if (found) begin
                wr_en         <= 1'b1;
                wr_stamp_only <= 1'b1;
                wr_valid      <= 1'b1;
                wr_addr       <= LW'(set_sel) * LW'(NUM_WAYS) + LW'(found_way);
              end else if (sacd_pkg::kind_t'(cur.kind) == sacd_pkg::KIND_WRITE) begin
                wr_en    <= 1'b1;
                wr_full  <= 1'b1;
                wr_valid <= 1'b1;
                wr_addr  <= LW'(set_sel) * LW'(NUM_WAYS)
                            + LW'(have_free ? free_way : old_way);
                found_way <= have_free ? free_way : old_way;
              end
            end
            sacd_pkg::KIND_FILL: begin
              wr_en    <= 1'b1;
              wr_full  <= 1'b1;
              wr_valid <= 1'b1;
              wr_addr  <= LW'(set_sel) * LW'(NUM_WAYS)
                          + LW'(have_free ? free_way : old_way);
              found     <= 1'b0;
              found_way <= have_free ? free_way : old_way;
            end
            default: ;
          endcase
        end
        ST_WALK_RD: begin
          state <= ST_WALK_CMP;
        end
        ST_WALK_CMP: begin
          if (rd_valid) begin
            case (sacd_pkg::kind_t'(cur.kind))
              sacd_pkg::KIND_INV_DEV: begin
                if (rd_dev == cur.device_id) begin
                  wr_en    <= 1'b1;
                  wr_addr  <= line_addr;
                  wr_valid <= 1'b0;
                end
              end
              sacd_pkg::KIND_FLUSH: begin
                wr_en    <= 1'b1;
                wr_addr  <= line_addr;
                wr_valid <= 1'b0;
                if (count != sacd_pkg::CountMax) count <= count + 1'b1;
              end
              default: begin
                if (count != sacd_pkg::CountMax) count <= count + 1'b1;
              end
            endcase
          end
          if (line_addr == LW'(Lines - 1)) begin
            state <= ST_RESP;
          end else begin
            line_addr <= line_addr + 1'b1;
            state     <= ST_WALK_RD;
          end
        end
        ST_RESP: begin
          // Waits here while the previous result is still unaccepted.
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out.line_count <= count;
            if (cur.kind <= 3'(sacd_pkg::KIND_INV_BLK)) begin
              out.hit       <= (sacd_pkg::kind_t'(cur.kind) == sacd_pkg::KIND_FILL) ? 1'b0 : found;
              out.set_index <= 6'(set_sel);
              out.way       <= 2'(found_way);
            end else begin
              out.hit       <= 1'b0;
              out.set_index <= '0;
              out.way       <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/sacd_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker of the cache directory
// Watches the handshakes on the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sacd_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_hit,
  input logic [8:0] rsp_line_count
);
  `CHK_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready, "ready held after accept")
  `CHK_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_hit) && $stable(rsp_line_count), "result changed while waiting")
  `CHK_NEXT(a_rsp_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
  `CHK_IMPLY(a_hit_no_count, clk, rst, rsp_valid && rsp_hit, rsp_line_count == 9'd0, "hit with count")
endmodule

bind set_assoc_block_cache_directory_top sacd_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.data.hit),
  .rsp_line_count(rsp.data.line_count)
);

@@ test/set_assoc_block_cache_directory_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the set-associative block cache directory
// Drives lookup, fill, write, invalidate, flush and count items through the
// request channel. It keeps its own copy of the directory to predict each
// result, and checks the response channel field by field, with random idle
// bursts on both channels.
// ----------------------------------------------------------------------------
module set_assoc_block_cache_directory_top_tb;

  localparam int unsigned Sets       = sacd_pkg::NumSetsDefault;
  localparam int unsigned Ways       = sacd_pkg::NumWaysDefault;
  localparam int unsigned Lines      = Sets * Ways;
  localparam int unsigned RandItems  = 930;
  localparam int unsigned QuietTail  = 150;
  localparam int unsigned StallLimit = 5000;

  typedef struct {
    sacd_pkg::req_t r;
    bit   drain;
  } pending_t;

  logic clk;
  logic rst;

  sacd_req_if req ();
  sacd_rsp_if rsp ();

  set_assoc_block_cache_directory_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted copy of the directory; valid bits start cleared.
  bit          dir_valid [Lines];
  logic [7:0]  dir_device[Lines];
  logic [47:0] dir_block [Lines];
  logic [31:0] dir_stamp [Lines];

  pending_t pending_items[$];
  sacd_pkg::rsp_t expected_rsps[$];

  int unsigned items_total;
  int unsigned items_sent;
  int unsigned rsps_seen;
  int unsigned mismatches;
  int unsigned hits_seen;
  int unsigned walks_seen;
  int unsigned evictions_seen;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned quiet_cycles;
  bit          stimulus_done;

  // Pool of addresses that gather in a few sets, so that ways fill and evict.
  logic [7:0]  pool_device[$];
  logic [47:0] pool_block[$];

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // FNV-1a over the zero-extended device id and block address, low byte first.
  function automatic logic [5:0] hash_set(input logic [7:0] dev, input logic [47:0] blk);
    logic [31:0] h;
    logic [63:0] d;
    logic [63:0] b;
    h = sacd_pkg::FnvBasis;
    d = {56'd0, dev};
    b = {16'd0, blk};
    for (int i = 0; i < 8; i++) begin
      h = (h ^ {24'd0, d[8*i +: 8]}) * sacd_pkg::FnvPrime;
    end
    for (int i = 0; i < 8; i++) begin
      h = (h ^ {24'd0, b[8*i +: 8]}) * sacd_pkg::FnvPrime;
    end
    return h[5:0];
  endfunction

  function automatic int match_way(input int base, input logic [7:0] dev,
                                   input logic [47:0] blk);
    for (int w = 0; w < Ways; w++) begin
      if (dir_valid[base + w] && dir_device[base + w] == dev && dir_block[base + w] == blk) begin
        return w;
      end
    end
    return -1;
  endfunction

  // First invalid way, else the oldest stamp with the lowest way on a tie.
  function automatic int choose_victim(input int base);
    int          v;
    logic [32:0] oldest;
    v = 0;
    oldest = 33'h1_FFFF_FFFF;
    for (int w = 0; w < Ways; w++) begin
      if (!dir_valid[base + w]) begin
        return w;
      end
      if ({1'b0, dir_stamp[base + w]} < oldest) begin
        oldest = {1'b0, dir_stamp[base + w]};
        v = w;
      end
    end
    evictions_seen++;
    return v;
  endfunction

  function automatic void place_line(input int l, input sacd_pkg::req_t r);
    dir_valid[l]  = 1'b1;
    dir_device[l] = r.device_id;
    dir_block[l]  = r.block_address;
    dir_stamp[l]  = r.now;
  endfunction

  // Applies one item to the directory copy and returns the result it gives.
  function automatic sacd_pkg::rsp_t apply_item(input sacd_pkg::req_t r);
    sacd_pkg::rsp_t res;
    int   base;
    int   w;
    int   cnt;
    res = '0;
    cnt = 0;
    case (sacd_pkg::kind_t'(r.kind))
      sacd_pkg::KIND_LOOKUP, sacd_pkg::KIND_FILL, sacd_pkg::KIND_WRITE,
      sacd_pkg::KIND_INV_BLK: begin
        res.set_index = hash_set(r.device_id, r.block_address);
        base = int'(res.set_index) * Ways;
        if (r.kind == sacd_pkg::KIND_LOOKUP) begin
          w = match_way(base, r.device_id, r.block_address);
          if (w >= 0) begin
            dir_stamp[base + w] = r.now;
            res.hit = 1'b1;
            res.way = w[1:0];
          end
        end else if (r.kind == sacd_pkg::KIND_FILL) begin
          w = choose_victim(base);
          place_line(base + w, r);
          res.way = w[1:0];
        end else if (r.kind == sacd_pkg::KIND_WRITE) begin
          w = match_way(base, r.device_id, r.block_address);
          if (w >= 0) begin
            dir_stamp[base + w] = r.now;
            res.hit = 1'b1;
          end else begin
            w = choose_victim(base);
            place_line(base + w, r);
          end
          res.way = w[1:0];
        end else begin
          for (w = Ways - 1; w >= 0; w--) begin
            if (dir_valid[base + w] && dir_device[base + w] == r.device_id
                && dir_block[base + w] == r.block_address) begin
              dir_valid[base + w] = 1'b0;
              res.hit = 1'b1;
              res.way = w[1:0];
            end
          end
        end
      end
      sacd_pkg::KIND_INV_DEV: begin
        for (int l = 0; l < Lines; l++) begin
          if (dir_valid[l] && dir_device[l] == r.device_id) begin
            dir_valid[l] = 1'b0;
          end
        end
      end
      sacd_pkg::KIND_FLUSH, sacd_pkg::KIND_COUNT: begin
        for (int l = 0; l < Lines; l++) begin
          if (dir_valid[l]) begin
            cnt++;
            if (r.kind == sacd_pkg::KIND_FLUSH) begin
              dir_valid[l] = 1'b0;
            end
          end
        end
        res.line_count = (cnt > int'(sacd_pkg::CountMax)) ? sacd_pkg::CountMax : cnt[8:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [47:0] rand_block();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic queue_item(input sacd_pkg::kind_t k, input logic [7:0] dev,
                            input logic [47:0] blk, input logic [31:0] now,
                            input bit drain = 1'b0);
    pending_t p;
    p.r.kind          = k;
    p.r.device_id     = dev;
    p.r.block_address = blk;
    p.r.now           = now;
    p.drain           = drain;
    pending_items.push_back(p);
    items_total++;
  endtask

  // Searches random block addresses until one hashes to the wanted set.
  function automatic logic [47:0] block_in_set(input logic [7:0] dev, input logic [5:0] s);
    logic [47:0] b;
    do begin
      b = rand_block();
    end while (hash_set(dev, b) != s);
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus. The directed part walks through the special cases first: misses
  // on an empty directory, the extremes of every field, a set filled beyond
  // its ways with tied stamps, a duplicate fill, both invalidate kinds, a
  // flush, a count and the unused kind. The random part then works mostly on
  // a small pool of addresses crowded into four sets.
  // --------------------------------------------------------------------------
  initial begin
    logic [47:0] same_set[6];
    logic [5:0]  s;
    logic [31:0] tick;
    int          pick;
    int          k;
    sacd_pkg::kind_t kd;
    logic [7:0]  dev;
    logic [47:0] blk;
    logic [31:0] now;

    // Directed part.
    queue_item(sacd_pkg::KIND_COUNT, 8'd0, 48'd0, 32'd0);
    queue_item(sacd_pkg::KIND_LOOKUP, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(sacd_pkg::KIND_FILL, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(sacd_pkg::KIND_LOOKUP, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'd7);
    queue_item(sacd_pkg::KIND_WRITE, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'd9);
    queue_item(sacd_pkg::KIND_WRITE, 8'd0, 48'd0, 32'd0);
    // Six blocks in one set: two evictions, the first decided by a stamp tie.
    s = hash_set(8'h5A, 48'd0);
    for (int i = 0; i < 6; i++) begin
      same_set[i] = block_in_set(8'h5A, s);
    end
    for (int i = 0; i < 4; i++) begin
      queue_item(sacd_pkg::KIND_FILL, 8'h5A, same_set[i], 32'd100);
    end
    queue_item(sacd_pkg::KIND_FILL, 8'h5A, same_set[4], 32'd101);
    queue_item(sacd_pkg::KIND_WRITE, 8'h5A, same_set[5], 32'd102);
    // A duplicate copy: the lookup must hit the lower way, and the invalidate
    // must clear both copies.
    queue_item(sacd_pkg::KIND_FILL, 8'h5A, same_set[5], 32'd103);
    queue_item(sacd_pkg::KIND_LOOKUP, 8'h5A, same_set[5], 32'd104);
    queue_item(sacd_pkg::KIND_INV_BLK, 8'h5A, same_set[5], 32'd105);
    queue_item(sacd_pkg::KIND_LOOKUP, 8'h5A, same_set[5], 32'd106);
    queue_item(sacd_pkg::KIND_INV_BLK, 8'h5A, same_set[5], 32'd107);
    queue_item(sacd_pkg::KIND_COUNT, 8'd0, 48'd0, 32'd0, 1'b1);
    queue_item(sacd_pkg::KIND_INV_DEV, 8'h5A, 48'd0, 32'd0);
    queue_item(sacd_pkg::KIND_LOOKUP, 8'h5A, same_set[4], 32'd108);
    queue_item(sacd_pkg::KIND_NONE, 8'hFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(sacd_pkg::KIND_FLUSH, 8'd0, 48'd0, 32'd0);
    queue_item(sacd_pkg::KIND_COUNT, 8'd0, 48'd0, 32'd0);

    // Address pool: six entries in each of four sets, over two fixed devices and random ones.
    for (int g = 0; g < 4; g++) begin
      s = 6'($urandom_range(0, Sets - 1));
      for (int i = 0; i < 6; i++) begin
        dev = (i % 3 == 0) ? 8'h01 : ((i % 3 == 1) ? 8'hC3 : 8'($urandom));
        pool_device.push_back(dev);
        pool_block.push_back(block_in_set(dev, s));
      end
    end

    // Random part.
    tick = 32'd200;
    for (int n = 0; n < RandItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kd = sacd_pkg::KIND_LOOKUP;
      else if (pick < 45) kd = sacd_pkg::KIND_FILL;
      else if (pick < 75) kd = sacd_pkg::KIND_WRITE;
      else if (pick < 87) kd = sacd_pkg::KIND_INV_BLK;
      else if (pick < 90) kd = sacd_pkg::KIND_INV_DEV;
      else if (pick < 92) kd = sacd_pkg::KIND_FLUSH;
      else if (pick < 97) kd = sacd_pkg::KIND_COUNT;
      else kd = sacd_pkg::KIND_NONE;
      if ($urandom_range(0, 99) < 80) begin
        k   = $urandom_range(0, pool_block.size() - 1);
        dev = pool_device[k];
        blk = pool_block[k];
      end else begin
        dev = 8'($urandom);
        blk = rand_block();
      end
      tick = tick + $urandom_range(0, 3);
      now  = ($urandom_range(0, 19) == 0) ? $urandom : tick;
      queue_item(kd, dev, blk, now, n == 400);
    end
    stimulus_done = 1'b1;
  end

  // Reset: held at the start and never again.
  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Idle bursts are off in one stretch of the middle and in the last items.
  function automatic bit idling_allowed();
    return !(items_sent >= 300 && items_sent < 420)
           && (items_total - items_sent > QuietTail);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Each accepted item is applied to the directory copy at once, and
  // its result joins the back of the expected queue. A new item is presented
  // only when the current one has been taken or none is showing.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(apply_item(req.data));
        items_sent++;
      end
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          req.valid <= 1'b0;
        end else if (pending_items[0].drain
                     && (expected_rsps.size() != 0 || (req.valid && req.ready))) begin
          // Hold off until every outstanding result has come back.
          req.valid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
          send_gap  <= $urandom_range(0, 9);
          req.valid <= 1'b0;
        end else begin
          req.data  <= pending_items.pop_front().r;
          req.valid <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted result is checked against the oldest expectation.
  // The ready line idles in random bursts while idling is allowed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sacd_pkg::rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsps_seen++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result with nothing expected: %p", rsp.data);
          end
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.data.hit !== want.hit || rsp.data.set_index !== want.set_index
              || rsp.data.way !== want.way || rsp.data.line_count !== want.line_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d: expected hit=%0d set=%0d way=%0d count=%0d,",
                       rsps_seen, want.hit, want.set_index, want.way, want.line_count);
              $display("       got hit=%0d set=%0d way=%0d count=%0d", rsp.data.hit,
                       rsp.data.set_index, rsp.data.way, rsp.data.line_count);
            end
          end else begin
            if (want.hit) hits_seen++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        rsp.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        recv_gap  <= $urandom_range(0, 9);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Watchdog: the longest waits come from a walk over all lines or the reset
  // sweep, so a long stretch with no item moving means the block is stuck.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no item moved for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    wait (pending_items.size() == 0 && items_sent == items_total && expected_rsps.size() == 0);
    repeat (50) @(posedge clk);
    $display("Run covered %0d items and %0d results, %0d of them hits, %0d evictions.",
             items_sent, rsps_seen, hits_seen, evictions_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_rsps.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
